// ===== rtl/msect_pkg.sv =====
// Shared types and constants for the multi-slot event countdown timer.
`default_nettype none

package msect_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMD_W  = 2;
    localparam int ID_W   = 16;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER = 2'd0,
        CMD_START    = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_STARTED    = 3'd2,
        KIND_NOT_FOUND  = 3'd3,
        KIND_EXPIRED    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]  dec;
        logic              count_zero;
        logic              expire;
        logic              id_match;
    } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/msect_slot_alu.sv =====
// Shared slot unit: count decrement, zero tests and id compare for one slot.
`default_nettype none

module msect_slot_alu (
    input  wire logic [msect_pkg::CNT_W-1:0] count,
    input  wire logic [msect_pkg::ID_W-1:0]  slot_id,
    input  wire logic [msect_pkg::ID_W-1:0]  key,
    output msect_pkg::alu_res_t              res
);
    import msect_pkg::*;

    always_comb begin
        res.dec        = count - CNT_W'(1);
        res.count_zero = (count == '0);
        res.expire     = (count == CNT_W'(1));
        res.id_match   = (slot_id == key);
    end

endmodule

`default_nettype wire

// ===== rtl/msect_out_reg.sv =====
// Output register for result transactions.
`default_nettype none

module msect_out_reg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push_valid,
    input  wire msect_pkg::res_t             push_res,
    output logic                             push_ready,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [msect_pkg::KIND_W-1:0]     m_kind,
    output logic [msect_pkg::ID_W-1:0]       m_event_id_res,
    output logic                             m_last
);
    import msect_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign push_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push_valid) begin
            res_reg <= push_res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_event_id_res = res_reg.id;
    assign m_last         = res_reg.last;

endmodule

`default_nettype wire

// ===== rtl/msect_ctrl.sv =====
// Sequencer, slot table: one slot per unstalled cycle through the shared slot unit.
`default_nettype none

module msect_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [msect_pkg::CMD_W-1:0] s_command,
    input  wire logic [msect_pkg::ID_W-1:0]  s_event_id,
    input  wire logic [msect_pkg::CNT_W-1:0] s_timer_value,
    input  wire logic                        s_repeat_req,
    output logic                             push_valid,
    output msect_pkg::res_t                  push_res,
    input  wire logic                        push_ready
);
    import msect_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic               pend_valid_reg, pend_valid_next;
    kind_t              pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;

    cmd_t               cmd_reg;
    logic [ID_W-1:0]    key_reg;
    logic [CNT_W-1:0]   tval_reg;
    logic               rep_reg;

    logic               slot_used_reg   [SLOTS];
    logic               slot_armed_reg  [SLOTS];
    logic               slot_repeat_reg [SLOTS];
    logic [ID_W-1:0]    slot_id_reg     [SLOTS];
    logic [CNT_W-1:0]   slot_count_reg  [SLOTS];
    logic [CNT_W-1:0]   slot_reload_reg [SLOTS];

    logic               accept;
    logic               last_idx;
    logic               cur_used;
    logic               cur_armed;
    logic               live;
    logic               wr_new;
    logic               wr_start;
    logic               wr_dec;
    logic               wr_expire;
    alu_res_t           alu;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign last_idx  = (idx_reg == IDX_W'(SLOTS - 1));
    assign cur_used  = slot_used_reg[idx_reg];
    assign cur_armed = slot_armed_reg[idx_reg];
    assign live      = cur_used && cur_armed && !alu.count_zero;

    msect_slot_alu u_alu (
        .count   (slot_count_reg[idx_reg]),
        .slot_id (slot_id_reg[idx_reg]),
        .key     (key_reg),
        .res     (alu)
    );

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        next_id_next    = next_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        push_valid      = 1'b0;
        push_res.kind   = pend_kind_reg;
        push_res.id     = pend_id_reg;
        push_res.last   = 1'b0;
        wr_new          = 1'b0;
        wr_start        = 1'b0;
        wr_dec          = 1'b0;
        wr_expire       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    if (cmd_t'(s_command) != CMD_NONE) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                case (cmd_reg)
                    CMD_REGISTER: begin
                        if (!cur_used) begin
                            pend_valid_next = 1'b1;
                            state_next      = ST_FLUSH;
                            if (next_id_reg != '0) begin
                                wr_new         = 1'b1;
                                pend_kind_next = KIND_REGISTERED;
                                pend_id_next   = next_id_reg;
                                next_id_next   = next_id_reg + ID_W'(1);
                            end else begin
                                pend_kind_next = KIND_FULL;
                                pend_id_next   = '0;
                            end
                        end else if (last_idx) begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_FULL;
                            pend_id_next    = '0;
                            state_next      = ST_FLUSH;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    CMD_START: begin
                        if (cur_used && alu.id_match) begin
                            wr_start        = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_STARTED;
                            pend_id_next    = key_reg;
                            state_next      = ST_FLUSH;
                        end else if (last_idx) begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_NOT_FOUND;
                            pend_id_next    = key_reg;
                            state_next      = ST_FLUSH;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    CMD_TICK: begin
                        if (!(live && alu.expire && pend_valid_reg && !push_ready)) begin
                            if (live && alu.expire) begin
                                push_valid      = pend_valid_reg;
                                wr_expire       = 1'b1;
                                pend_valid_next = 1'b1;
                                pend_kind_next  = KIND_EXPIRED;
                                pend_id_next    = slot_id_reg[idx_reg];
                            end else if (live) begin
                                wr_dec = 1'b1;
                            end
                            if (last_idx) begin
                                state_next = ST_FLUSH;
                            end else begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (push_ready) begin
                    push_valid      = 1'b1;
                    push_res.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            next_id_reg    <= ID_W'(1);
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_used_reg[i]  <= 1'b0;
                slot_armed_reg[i] <= 1'b0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            next_id_reg    <= next_id_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_new) begin
                slot_used_reg[idx_reg]  <= 1'b1;
                slot_armed_reg[idx_reg] <= 1'b0;
            end
            if (wr_start) begin
                slot_armed_reg[idx_reg] <= 1'b1;
            end
            if (wr_expire && !slot_repeat_reg[idx_reg]) begin
                slot_used_reg[idx_reg]  <= 1'b0;
                slot_armed_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        if (accept) begin
            cmd_reg  <= cmd_t'(s_command);
            key_reg  <= s_event_id;
            tval_reg <= s_timer_value;
            rep_reg  <= s_repeat_req;
        end
        if (wr_new) begin
            slot_id_reg[idx_reg] <= next_id_reg;
        end
        if (wr_start) begin
            slot_count_reg[idx_reg]  <= tval_reg;
            slot_reload_reg[idx_reg] <= tval_reg;
            slot_repeat_reg[idx_reg] <= rep_reg;
        end
        if (wr_dec) begin
            slot_count_reg[idx_reg] <= alu.dec;
        end
        if (wr_expire) begin
            slot_count_reg[idx_reg] <= slot_reload_reg[idx_reg];
        end
    end

    ast_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("result pushed into a full output register");

    ast_flush_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && state_reg == ST_FLUSH && pend_valid_reg && !push_ready)
        |=> state_reg == ST_FLUSH)
        else $error("pending result dropped while output stalled");

    ast_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && push_valid && push_res.last) |=> state_reg == ST_IDLE)
        else $error("final result not followed by idle");

    ast_id_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !(state_reg == ST_SCAN && cmd_reg == CMD_REGISTER))
        |=> $stable(next_id_reg))
        else $error("next id changed outside a register transaction");

endmodule

`default_nettype wire

// ===== rtl/multi_slot_event_countdown_timer.sv =====
// Multi-slot event countdown timer top level.
//
// Input channel (s_valid/s_ready) carries one command per transaction:
// register a new event, start an event's countdown by id, or one tick.
// Result channel (m_valid/m_ready) carries kind, event id and a last flag.
// Register and start give exactly one result; a tick gives one expiry per
// slot that reaches zero, in slot order, the final one with m_last set, or
// no result at all. Command 3 is dropped without a result.
// Every command but command 3 walks the slot table one slot per cycle through
// a single shared decrement/compare unit, a tick sweep pausing as below:
// register stops at the first free slot, start at the matching id, a tick visits all.
// s_ready is high only while the sequencer is idle; a result may still sit
// in the output register when the next command is taken.
// A stalled receiver holds the output register; a tick sweep then pauses at
// the next expiry until the pending result can move on.
// Synchronous active-low reset clears the slot used and armed flags, sets
// the next id to 1 and empties the output register; no clearing pass.
`default_nettype none

module multi_slot_event_countdown_timer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [msect_pkg::CMD_W-1:0] s_command,
    input  wire logic [msect_pkg::ID_W-1:0]  s_event_id,
    input  wire logic [msect_pkg::CNT_W-1:0] s_timer_value,
    input  wire logic                        s_repeat_req,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [msect_pkg::KIND_W-1:0]     m_kind,
    output logic [msect_pkg::ID_W-1:0]       m_event_id_res,
    output logic                             m_last
);
    import msect_pkg::*;

    logic push_valid;
    logic push_ready;
    res_t push_res;

    msect_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_event_id    (s_event_id),
        .s_timer_value (s_timer_value),
        .s_repeat_req  (s_repeat_req),
        .push_valid    (push_valid),
        .push_res      (push_res),
        .push_ready    (push_ready)
    );

    msect_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push_valid     (push_valid),
        .push_res       (push_res),
        .push_ready     (push_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_event_id_res (m_event_id_res),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire
